FILE: rtl/core/rte_pkg.sv
// shared types, codes and reset values of the retransmit timer engine
package rte_pkg;

   // sizes
   localparam int SLOTS_DEF = 16;
   localparam int SLOT_W    = 8;
   localparam int Q_DEPTH   = 2;
   localparam int CSR_AW    = 5;

   // item operations
   localparam logic [1:0] OP_TRACK  = 2'd0;
   localparam logic [1:0] OP_ACK    = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   // result kinds
   localparam logic [2:0] K_DONE   = 3'd0;
   localparam logic [2:0] K_ACC    = 3'd1;
   localparam logic [2:0] K_REJ    = 3'd2;
   localparam logic [2:0] K_TRS    = 3'd3;
   localparam logic [2:0] K_FRS    = 3'd4;
   localparam logic [2:0] K_GIVEUP = 3'd5;

   // slot phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_FAIL = 2'd2;

   // register indexes
   localparam logic [2:0] REG_INIT_TO = 3'd0;
   localparam logic [2:0] REG_MIN_TO  = 3'd1;
   localparam logic [2:0] REG_MAX_TO  = 3'd2;
   localparam logic [2:0] REG_DUP_THR = 3'd3;
   localparam logic [2:0] REG_RETRY   = 3'd4;
   localparam logic [2:0] REG_MAX_LEN = 3'd5;

   // register reset values
   localparam logic [31:0] RST_INIT_TO = 32'd1000;
   localparam logic [31:0] RST_MIN_TO  = 32'd200;
   localparam logic [31:0] RST_MAX_TO  = 32'd60000;
   localparam logic [7:0]  RST_DUP_THR = 8'd3;
   localparam logic [7:0]  RST_RETRY   = 8'd5;
   localparam logic [15:0] RST_MAX_LEN = 16'd1500;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  slot;
      logic [31:0] seq_num;
      logic [15:0] seg_len;
      logic [31:0] ack_num;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_slot;
      logic [31:0] out_seq;
      logic [15:0] out_len;
      logic [31:0] out_timeout;
      logic [15:0] in_flight;
      logic [31:0] resend_total;
      logic [31:0] abandon_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] init_to;
      logic [31:0] min_to;
      logic [31:0] max_to;
      logic [7:0]  dup_thr;
      logic [7:0]  retry_lim;
      logic [15:0] max_len;
   } cfg_type;

   typedef struct packed {
      req_type req;
      logic    in_range;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [31:0] seq;
      logic [15:0] len;
      logic [31:0] start;
      logic [7:0]  retries;
      logic        resent;
      logic [7:0]  dup;
      logic [31:0] timeout;
      logic [31:0] srtt;
      logic [31:0] rttvar;
      logic [31:0] last_ack;
   } slot_type;

endpackage

FILE: rtl/core/rte_fifo.sv
// small first-in first-out queue
module rte_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rte_pkg::Q_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   // status and handshakes
   assign full    = (cnt_ff == (PW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/core/rte_csr.sv
// configuration registers behind the apb-style port
module rte_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rte_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output rte_pkg::cfg_type           cfg
);
   import rte_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr_en;

   assign idx    = paddr[CSR_AW-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_INIT_TO: cfg_in.init_to   = pwdata;
            REG_MIN_TO:  cfg_in.min_to    = pwdata;
            REG_MAX_TO:  cfg_in.max_to    = pwdata;
            REG_DUP_THR: cfg_in.dup_thr   = pwdata[7:0];
            REG_RETRY:   cfg_in.retry_lim = pwdata[7:0];
            REG_MAX_LEN: cfg_in.max_len   = pwdata[15:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   // register read
   always_comb begin
      case (idx)
         REG_INIT_TO: prdata = cfg_ff.init_to;
         REG_MIN_TO:  prdata = cfg_ff.min_to;
         REG_MAX_TO:  prdata = cfg_ff.max_to;
         REG_DUP_THR: prdata = {24'd0, cfg_ff.dup_thr};
         REG_RETRY:   prdata = {24'd0, cfg_ff.retry_lim};
         REG_MAX_LEN: prdata = {16'd0, cfg_ff.max_len};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_to   <= RST_INIT_TO;
         cfg_ff.min_to    <= RST_MIN_TO;
         cfg_ff.max_to    <= RST_MAX_TO;
         cfg_ff.dup_thr   <= RST_DUP_THR;
         cfg_ff.retry_lim <= RST_RETRY;
         cfg_ff.max_len   <= RST_MAX_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/rte_front.sv
// front end: accepts items, tags the slot range and queues them for the back end
module rte_front #(
   parameter int SLOTS = rte_pkg::SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rte_pkg::req_type req_data,
   output logic             full,
   output rte_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);
   import rte_pkg::*;

   cmd_type                cmd_wr;
   logic [$bits(cmd_type)-1:0] cmd_raw;
   logic                   cmd_empty;

   // classify the item
   always_comb begin
      cmd_wr.req      = req_data;
      cmd_wr.in_range = (req_data.slot < SLOT_W'(SLOTS));
   end

   // command queue
   rte_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (Q_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cmd_wr),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_raw),
      .empty (cmd_empty)
   );

   assign cmd       = cmd_type'(cmd_raw);
   assign cmd_valid = !cmd_empty;

endmodule

FILE: rtl/core/rte_back.sv
// back end: slot store and the sequencer that carries out each item
module rte_back #(
   parameter int SLOTS = rte_pkg::SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  rte_pkg::cfg_type cfg,
   input  rte_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   output logic             out_push,
   output rte_pkg::rsp_type out_data,
   input  logic             out_full
);
   import rte_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_RTT1 = 3'd3;
   localparam logic [2:0] ST_RTT2 = 3'd4;
   localparam logic [2:0] ST_RTT3 = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   logic [2:0]  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] resend_ff, resend_in;
   logic [31:0] giveup_ff, giveup_in;
   logic [31:0] sample_ff, sample_in;
   slot_type    ent_ff, ent_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  oslot_ff, oslot_in;
   logic        show_ff, show_in;
   logic        seg_ff, seg_in;
   logic        last_ff, last_in;
   logic        wr_ff, wr_in;

   slot_type    mem [SLOTS];
   logic [SLOTS-1:0] vld_ff;
   slot_type    rd_ff;
   logic        rdv_ff;

   slot_type    cur;
   logic [AW-1:0] addr;
   logic        is_tick;
   logic        mem_we;

   assign is_tick = (cmd_ff.req.op == OP_TICK);
   assign addr    = is_tick ? scan_ff : cmd_ff.req.slot[AW-1:0];
   assign cur     = rdv_ff ? rd_ff : '0;
   assign mem_we  = (state_ff == ST_EMIT) && !out_full && wr_ff;
   assign out_push = ((state_ff == ST_EMIT) || (state_ff == ST_FIN)) && !out_full;

   // result built from the registered outcome
   always_comb begin
      out_data.kind          = kind_ff;
      out_data.out_slot      = oslot_ff;
      out_data.out_seq       = seg_ff ? ent_ff.seq : '0;
      out_data.out_len       = seg_ff ? ent_ff.len : '0;
      out_data.out_timeout   = show_ff ? ent_ff.timeout : '0;
      out_data.in_flight     = (show_ff && ent_ff.phase == PH_WAIT) ? ent_ff.len : '0;
      out_data.resend_total  = resend_ff;
      out_data.abandon_total = giveup_ff;
      out_data.last          = last_ff;
   end

   // sequencer
   always_comb begin
      logic [7:0]  dup_n;
      logic [32:0] dbl;
      logic [31:0] diff;
      logic [33:0] sum;
      logic [33:0] clmp;
      logic        adv;

      state_in  = state_ff;
      cmd_in    = cmd_ff;
      scan_in   = scan_ff;
      now_in    = now_ff;
      resend_in = resend_ff;
      giveup_in = giveup_ff;
      sample_in = sample_ff;
      ent_in    = ent_ff;
      kind_in   = kind_ff;
      oslot_in  = oslot_ff;
      show_in   = show_ff;
      seg_in    = seg_ff;
      last_in   = last_ff;
      wr_in     = wr_ff;
      cmd_pop   = 1'b0;
      adv       = 1'b0;
      dup_n     = (cur.dup == 8'hFF) ? cur.dup : cur.dup + 8'd1;
      dbl       = {cur.timeout, 1'b0};
      diff      = (sample_ff > ent_ff.srtt) ? sample_ff - ent_ff.srtt
                                             : ent_ff.srtt - sample_ff;
      sum       = {2'b00, ent_ff.srtt} + {ent_ff.rttvar, 2'b00};
      clmp      = (sum < {2'b00, cfg.min_to}) ? {2'b00, cfg.min_to} : sum;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               scan_in  = '0;
               state_in = ST_READ;
               if (cmd.req.op == OP_TICK) begin
                  now_in = now_ff + 32'd1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            ent_in   = cur;
            oslot_in = cmd_ff.req.slot;
            show_in  = cmd_ff.in_range;
            seg_in   = 1'b0;
            last_in  = 1'b1;
            wr_in    = 1'b0;
            kind_in  = K_DONE;
            state_in = ST_EMIT;
            case (cmd_ff.req.op)
               OP_TRACK: begin
                  if (!cmd_ff.in_range || cmd_ff.req.seg_len == 16'd0 ||
                      cmd_ff.req.seg_len > cfg.max_len) begin
                     kind_in = K_REJ;
                  end else begin
                     ent_in.seq     = cmd_ff.req.seq_num;
                     ent_in.len     = cmd_ff.req.seg_len;
                     ent_in.start   = now_ff;
                     ent_in.retries = '0;
                     ent_in.phase   = PH_WAIT;
                     ent_in.resent  = 1'b0;
                     ent_in.dup     = '0;
                     if (cur.timeout == '0) begin
                        ent_in.timeout = cfg.init_to;
                     end
                     wr_in   = 1'b1;
                     kind_in = K_ACC;
                  end
               end
               OP_ACK: begin
                  if (cmd_ff.in_range && cur.phase == PH_WAIT) begin
                     wr_in = 1'b1;
                     if (cmd_ff.req.ack_num >= cur.seq + {16'd0, cur.len}) begin
                        ent_in.phase    = PH_IDLE;
                        ent_in.retries  = '0;
                        ent_in.dup      = '0;
                        ent_in.last_ack = cmd_ff.req.ack_num;
                        if (!cur.resent) begin
                           state_in = ST_RTT1;
                        end
                     end else if (cmd_ff.req.ack_num == cur.last_ack) begin
                        if (dup_n >= cfg.dup_thr) begin
                           resend_in     = resend_ff + 32'd1;
                           ent_in.resent = 1'b1;
                           ent_in.dup    = '0;
                           kind_in       = K_FRS;
                           seg_in        = 1'b1;
                        end else begin
                           ent_in.dup = dup_n;
                        end
                     end else begin
                        ent_in.last_ack = cmd_ff.req.ack_num;
                        ent_in.dup      = '0;
                     end
                  end
               end
               OP_CANCEL: begin
                  if (cmd_ff.in_range) begin
                     ent_in.phase   = PH_IDLE;
                     ent_in.retries = '0;
                     ent_in.timeout = '0;
                     ent_in.srtt    = '0;
                     ent_in.rttvar  = '0;
                     ent_in.dup     = '0;
                     wr_in          = 1'b1;
                  end
               end
               default: begin
                  // tick scan of one slot
                  oslot_in = SLOT_W'(scan_ff);
                  show_in  = 1'b1;
                  seg_in   = 1'b1;
                  last_in  = 1'b0;
                  if (cur.phase == PH_WAIT && (now_ff - cur.start) >= cur.timeout) begin
                     wr_in = 1'b1;
                     if (cur.retries >= cfg.retry_lim) begin
                        ent_in.phase = PH_FAIL;
                        giveup_in    = giveup_ff + 32'd1;
                        kind_in      = K_GIVEUP;
                     end else begin
                        resend_in      = resend_ff + 32'd1;
                        ent_in.resent  = 1'b1;
                        ent_in.timeout = (dbl > {1'b0, cfg.max_to}) ? cfg.max_to
                                                                    : dbl[31:0];
                        if (cur.retries != 8'hFF) begin
                           ent_in.retries = cur.retries + 8'd1;
                        end
                        ent_in.start = now_ff;
                        kind_in      = K_TRS;
                     end
                  end else begin
                     adv = 1'b1;
                  end
               end
            endcase
         end
         ST_RTT1: begin
            sample_in = now_ff - ent_ff.start;
            state_in  = ST_RTT2;
         end
         ST_RTT2: begin
            if (ent_ff.srtt == '0) begin
               ent_in.srtt   = sample_ff;
               ent_in.rttvar = sample_ff >> 1;
            end else begin
               ent_in.rttvar = ent_ff.rttvar - (ent_ff.rttvar >> 2) + (diff >> 2);
               ent_in.srtt   = ent_ff.srtt - (ent_ff.srtt >> 3) + (sample_ff >> 3);
            end
            state_in = ST_RTT3;
         end
         ST_RTT3: begin
            ent_in.timeout = (clmp > {2'b00, cfg.max_to}) ? cfg.max_to : clmp[31:0];
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_full) begin
               if (is_tick) begin
                  adv = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN: begin
            if (!out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // step to the next slot of a tick scan, or to its closing item
      if (adv) begin
         if (scan_ff == AW'(SLOTS-1)) begin
            kind_in  = K_DONE;
            oslot_in = '0;
            show_in  = 1'b0;
            seg_in   = 1'b0;
            last_in  = 1'b1;
            wr_in    = 1'b0;
            state_in = ST_FIN;
         end else begin
            scan_in  = scan_ff + 1'b1;
            state_in = ST_READ;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         now_ff    <= '0;
         resend_ff <= '0;
         giveup_ff <= '0;
         vld_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         now_ff    <= now_in;
         resend_ff <= resend_in;
         giveup_ff <= giveup_in;
         if (mem_we) begin
            vld_ff[addr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      scan_ff   <= scan_in;
      sample_ff <= sample_in;
      ent_ff    <= ent_in;
      kind_ff   <= kind_in;
      oslot_ff  <= oslot_in;
      show_ff   <= show_in;
      seg_ff    <= seg_in;
      last_ff   <= last_in;
      wr_ff     <= wr_in;
   end

   // slot store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= ent_ff;
      end
      rd_ff  <= mem[addr];
      rdv_ff <= vld_ff[addr];
   end

   // checks
   a_exec_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> ($past(state_ff) == ST_READ))
      else $error("slot decided without a fresh read");

   a_push_states: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (state_ff == ST_EMIT || state_ff == ST_FIN))
      else $error("result pushed outside an emit state");

   a_resend_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC) |=> $stable(resend_ff))
      else $error("resend count moved outside slot execution");

   a_giveup_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC) |=> $stable(giveup_ff))
      else $error("give-up count moved outside slot execution");

endmodule

FILE: rtl/core/retransmit_timer_engine.sv
// Retransmit timer engine: per-slot timeout, rtt and fast retransmit tracker.
// Track, ack and cancel go from the command queue to the result queue: read, decide, then write
// back through the slot store port, with rtt update steps for an ack that takes an rtt sample.
// A tick scans every slot in turn, with a result for each expired slot, then a closing item.
// Synchronous active-high reset invalidates all slots, clears counters and state, loads cfg defaults.
module retransmit_timer_engine #(
   parameter int SLOTS = rte_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rte_pkg::req_type           req_data,
   output logic                       full,
   input  logic                       pop,
   output rte_pkg::rsp_type           rsp_data,
   output logic                       empty,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rte_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import rte_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    out_push;
   rsp_type out_data;
   logic    out_full;
   logic [$bits(rsp_type)-1:0] rsp_raw;

   // configuration registers
   rte_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // item intake
   rte_front #(.SLOTS(SLOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // slot engine
   rte_back #(.SLOTS(SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .out_push  (out_push),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   // result queue
   rte_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (Q_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (pop),
      .rdata (rsp_raw),
      .empty (empty)
   );

   assign rsp_data = rsp_type'(rsp_raw);

endmodule
